// File: rtl/string_key_bucket_hash_top_assert.svh
// Assertion macros shared by the string key bucket hash modules.
`ifndef STRING_KEY_BUCKET_HASH_TOP_ASSERT_SVH
`define STRING_KEY_BUCKET_HASH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKBH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define SKBH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`endif

// File: rtl/skbh_pkg.sv
// Package with the types, constants and hash functions of the string key bucket hash.
`timescale 1ns / 1ps

package skbh_pkg;

    localparam int unsigned LOG2_W = 5;
    localparam int unsigned BUCKET_W = 16;
    localparam int unsigned CRC_W = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] KNUTH_MULT = 32'd2654435761;
    localparam logic [LOG2_W-1:0] MAX_TABLE_LOG2 = 5'd16;
    localparam logic [LOG2_W-1:0] TABLE_LOG2_RESET = 5'd8;

    // Working hash value and the raw CRC of the key, passed between stages.
    typedef struct packed {
        logic [CRC_W-1:0] hash;
        logic [CRC_W-1:0] crc;
    } skbh_word_t;

    // Reflected CRC-32 update with one byte, no inversion.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'b0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // First half of the 32-bit shift/add/xor mix.
    function automatic logic [CRC_W-1:0] mix_front(input logic [CRC_W-1:0] k_in);
        logic [CRC_W-1:0] k;
        k = k_in;
        k = k + (k << 12);
        k = k ^ (k >> 22);
        k = k + (k << 4);
        k = k ^ (k >> 9);
        return k;
    endfunction

    // Second half of the 32-bit shift/add/xor mix.
    function automatic logic [CRC_W-1:0] mix_back(input logic [CRC_W-1:0] k_in);
        logic [CRC_W-1:0] k;
        k = k_in;
        k = k + (k << 10);
        k = k ^ (k >> 2);
        k = k + (k << 7);
        k = k ^ (k >> 12);
        return k;
    endfunction

endpackage

// File: rtl/skbh_crc.sv
// Running CRC-32 over the key bytes and the register that holds a finished key CRC.
`timescale 1ns / 1ps
`include "string_key_bucket_hash_top_assert.svh"

module skbh_crc
    import skbh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    output skbh_word_t out_word,
    input  logic       out_ready
);

    logic [CRC_W-1:0] running_crc_reg;
    logic [CRC_W-1:0] running_crc_next;
    logic [CRC_W-1:0] crc_upd;
    logic             valid_reg;
    logic             valid_next;
    skbh_word_t       word_reg;
    skbh_word_t       word_next;
    logic             accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign crc_upd = crc_byte(running_crc_reg, in_byte);

    always_comb
    begin
        running_crc_next = running_crc_reg;
        valid_next = valid_reg && !out_ready;
        word_next = word_reg;
        if (accept)
        begin
            running_crc_next = in_last ? '0 : crc_upd;
            if (in_last)
            begin
                valid_next = 1'b1;
                word_next.hash = crc_upd;
                word_next.crc = crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word = word_reg;

    `SKBH_ASSERT_NEXT(a_crc_clear_on_last, clk, rst_n, accept && in_last, running_crc_reg == '0)
    `SKBH_ASSERT_NEXT(a_crc_result_loaded, clk, rst_n, accept && in_last, valid_reg)
    `SKBH_ASSERT_NEXT(a_crc_result_held, clk, rst_n, valid_reg && !out_ready,
                      valid_reg && $stable(word_reg))

endmodule

// File: rtl/skbh_mix.sv
// Two pipeline stages that apply the shift/add/xor mix to a finished key CRC.
`timescale 1ns / 1ps
`include "string_key_bucket_hash_top_assert.svh"

module skbh_mix
    import skbh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  skbh_word_t in_word,
    output logic       out_valid,
    output skbh_word_t out_word,
    input  logic       out_ready
);

    logic       front_valid_reg;
    logic       front_valid_next;
    skbh_word_t front_word_reg;
    skbh_word_t front_word_next;
    logic       back_valid_reg;
    logic       back_valid_next;
    skbh_word_t back_word_reg;
    skbh_word_t back_word_next;
    logic       back_ready;

    assign back_ready = !back_valid_reg || out_ready;
    assign in_ready = !front_valid_reg || back_ready;

    always_comb
    begin
        front_valid_next = front_valid_reg && !back_ready;
        front_word_next = front_word_reg;
        if (in_valid && in_ready)
        begin
            front_valid_next = 1'b1;
            front_word_next.hash = mix_front(in_word.hash);
            front_word_next.crc = in_word.crc;
        end
    end

    always_comb
    begin
        back_valid_next = back_valid_reg && !out_ready;
        back_word_next = back_word_reg;
        if (front_valid_reg && back_ready)
        begin
            back_valid_next = 1'b1;
            back_word_next.hash = mix_back(front_word_reg.hash);
            back_word_next.crc = front_word_reg.crc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            back_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
            back_valid_reg <= back_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_word_reg <= front_word_next;
        back_word_reg <= back_word_next;
    end

    assign out_valid = back_valid_reg;
    assign out_word = back_word_reg;

    `SKBH_ASSERT_NEXT(a_mix_front_moves, clk, rst_n, front_valid_reg && back_ready,
                      back_valid_reg)
    `SKBH_ASSERT_NEXT(a_mix_back_held, clk, rst_n, back_valid_reg && !out_ready,
                      back_valid_reg && $stable(back_word_reg))

endmodule

// File: rtl/skbh_scale.sv
// Multiplicative scaling, table size masking and the result register.
`timescale 1ns / 1ps

module skbh_scale
    import skbh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  skbh_word_t          in_word,
    input  logic [LOG2_W-1:0]   table_log2,
    output logic                out_valid,
    output logic [BUCKET_W-1:0] out_bucket,
    output logic [CRC_W-1:0]    out_crc,
    input  logic                out_ready
);

    logic [CRC_W-1:0]    shifted;
    logic [CRC_W-1:0]    product;
    logic [LOG2_W-1:0]   log2_sat;
    logic [BUCKET_W-1:0] mask_full;
    logic                valid_reg;
    logic                valid_next;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [BUCKET_W-1:0] bucket_next;
    logic [CRC_W-1:0]    crc_reg;
    logic [CRC_W-1:0]    crc_next;

    assign in_ready = !valid_reg || out_ready;
    assign shifted = in_word.hash >> 3;
    assign product = shifted * KNUTH_MULT;
    assign log2_sat = (table_log2 > MAX_TABLE_LOG2) ? MAX_TABLE_LOG2 : table_log2;
    assign mask_full = ~({BUCKET_W{1'b1}} << log2_sat);

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        bucket_next = bucket_reg;
        crc_next = crc_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
            bucket_next = product[BUCKET_W-1:0] & mask_full;
            crc_next = in_word.crc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bucket_reg <= bucket_next;
        crc_reg <= crc_next;
    end

    assign out_valid = valid_reg;
    assign out_bucket = bucket_reg;
    assign out_crc = crc_reg;

endmodule

// File: rtl/string_key_bucket_hash_top.sv
// Top level of the string key bucket hash: CRC, mix and scaling stages.
//
//   Channel    Direction  Payload
//   s_axis     in         tdata[7:0] key_byte, tlast last_byte
//   m_axis     out        tdata[15:0] bucket_index, tdata[47:16] key_crc
//   cfg        in         cfg_wdata[4:0] table_size_log2 (written when cfg_wen)
//
// While s_axis_tready is high, one key byte is taken and CRC-updated per cycle.
// A key's result goes through the CRC, mix front, mix back and scale registers.
// Each of the four stages has its own valid bit, so a stall fills bubbles first.
// Reset clears the running CRC and all valid bits and sets table_size_log2 to 8.
`timescale 1ns / 1ps

module string_key_bucket_hash_top
    import skbh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // [7:0] key_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,  // [15:0] bucket_index, [47:16] key_crc
    input  logic              cfg_wen,
    input  logic [LOG2_W-1:0] cfg_wdata
);

    logic [LOG2_W-1:0]   table_log2_q_reg;
    logic [LOG2_W-1:0]   table_log2_next;
    logic                crc_valid;
    logic                crc_ready;
    skbh_word_t          crc_word;
    logic                mix_valid;
    logic                mix_ready;
    skbh_word_t          mix_word;
    logic [BUCKET_W-1:0] bucket;
    logic [CRC_W-1:0]    key_crc;

    assign table_log2_next = cfg_wen ? cfg_wdata : table_log2_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_log2_q_reg <= TABLE_LOG2_RESET;
        end
        else
        begin
            table_log2_q_reg <= table_log2_next;
        end
    end

    skbh_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (crc_valid),
        .out_word  (crc_word),
        .out_ready (crc_ready)
    );

    skbh_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (crc_valid),
        .in_ready  (crc_ready),
        .in_word   (crc_word),
        .out_valid (mix_valid),
        .out_word  (mix_word),
        .out_ready (mix_ready)
    );

    skbh_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mix_valid),
        .in_ready   (mix_ready),
        .in_word    (mix_word),
        .table_log2 (table_log2_q_reg),
        .out_valid  (m_axis_tvalid),
        .out_bucket (bucket),
        .out_crc    (key_crc),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {key_crc, bucket};

endmodule

// File: tb/string_key_bucket_hash_top_test.sv
// Self-checking testbench for the string key bucket hash top level.
`timescale 1ns / 1ps

module string_key_bucket_hash_top_test;

    import skbh_pkg::*;

    typedef struct {
        logic [BUCKET_W-1:0] bucket;
        logic [CRC_W-1:0]    crc;
    } bucket_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] key_byte
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [47:0]       m_axis_tdata;   // [15:0] bucket_index, [47:16] key_crc
    logic              cfg_wen;
    logic [LOG2_W-1:0] cfg_wdata;

    logic [CRC_W-1:0]  crc_table [256];
    logic [CRC_W-1:0]  key_crc_so_far;
    logic [LOG2_W-1:0] table_log2_now;
    bucket_result_t    expected_results [$];
    int unsigned       mismatch_count;
    int unsigned       bytes_sent;
    bit                tx_idle_on;
    bit                rx_idle_on;

    string_key_bucket_hash_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("string_key_bucket_hash_top: mismatch");
        $finish;
    end

    function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
        logic [7:0] idx;
        idx = crc[7:0] ^ b;
        return (crc >> 8) ^ crc_table[idx];
    endfunction

    function automatic logic [BUCKET_W-1:0] predict_bucket(input logic [CRC_W-1:0] crc,
                                                          input logic [LOG2_W-1:0] lg);
        logic [CRC_W-1:0]  k;
        logic [63:0]       prod;
        logic [LOG2_W-1:0] bits_kept;
        logic [CRC_W-1:0]  mask;
        logic [CRC_W-1:0]  scaled;
        k = crc;
        k = k + (k << 12);
        k = k ^ (k >> 22);
        k = k + (k << 4);
        k = k ^ (k >> 9);
        k = k + (k << 10);
        k = k ^ (k >> 2);
        k = k + (k << 7);
        k = k ^ (k >> 12);
        prod = {32'b0, k >> 3} * {32'b0, KNUTH_MULT};
        bits_kept = (lg > MAX_TABLE_LOG2) ? MAX_TABLE_LOG2 : lg;
        mask = (32'd1 << bits_kept) - 32'd1;
        scaled = prod[31:0] & mask;
        return scaled[BUCKET_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_key_byte(input logic [7:0] b, input logic is_last);
        int unsigned gap;
        bucket_result_t r;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        key_crc_so_far = crc_next(key_crc_so_far, b);
        if (is_last)
        begin
            r.bucket = predict_bucket(key_crc_so_far, table_log2_now);
            r.crc    = key_crc_so_far;
            expected_results.push_back(r);
            key_crc_so_far = '0;
        end
        @(negedge clk);
    endtask

    task automatic wait_block_idle();
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_table_size(input logic [LOG2_W-1:0] v);
        cfg_wdata = v;
        cfg_wen   = 1'b1;
        @(negedge clk);
        cfg_wen        = 1'b0;
        table_log2_now = v;
    endtask

    function automatic logic [7:0] pick_key_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'($urandom_range(8'h20, 8'h7E));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_key(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_key_byte(pick_key_byte(), i == len - 1);
    endtask

    task automatic test_default_table_size();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_key_byte(8'h00, 1'b1);
        send_key_byte(8'hFF, 1'b1);
        send_key_byte(8'h61, 1'b0);
        send_key_byte(8'h62, 1'b1);
        wait_block_idle();
    endtask

    task automatic test_table_size_extremes();
        logic [LOG2_W-1:0] sizes [5];
        sizes = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
        foreach (sizes[i])
        begin
            tx_idle_on = i[0];
            rx_idle_on = ~i[0];
            write_table_size(sizes[i]);
            send_key_byte(8'hFF, 1'b0);
            send_key_byte(8'h00, 1'b0);
            send_key_byte(8'($urandom_range(0, 255)), 1'b1);
            wait_block_idle();
        end
    endtask

    task automatic test_random_keys();
        int unsigned key_count;
        int unsigned len;
        while (bytes_sent < 1650)
        begin
            write_table_size(LOG2_W'($urandom_range(0, 31)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            key_count = $urandom_range(20, 60);
            for (int unsigned n = 0; n < key_count; n++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                send_random_key(len);
            end
            wait_block_idle();
        end
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int unsigned stall;
            @(negedge clk);
            stall = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Every output transaction is compared with the oldest predicted result.
    always @(posedge clk)
    begin
        bucket_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, actual bucket_index %0h key_crc %08h",
                         $time, m_axis_tdata[15:0], m_axis_tdata[47:16]);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[15:0] !== want.bucket)
                begin
                    mismatch_count++;
                    $display("%0t: bucket_index expected %04h actual %04h",
                             $time, want.bucket, m_axis_tdata[15:0]);
                end
                if (m_axis_tdata[47:16] !== want.crc)
                begin
                    mismatch_count++;
                    $display("%0t: key_crc expected %08h actual %08h",
                             $time, want.crc, m_axis_tdata[47:16]);
                end
            end
        end
    end

    initial
    begin
        logic [CRC_W-1:0] c;
        for (int i = 0; i < 256; i++)
        begin
            c = CRC_W'(i);
            for (int j = 0; j < 8; j++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            crc_table[i] = c;
        end
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        cfg_wen        = 1'b0;
        cfg_wdata      = '0;
        key_crc_so_far = '0;
        table_log2_now = TABLE_LOG2_RESET;
        mismatch_count = 0;
        bytes_sent     = 0;
        tx_idle_on     = 1'b0;
        rx_idle_on     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_table_size();
        test_table_size_extremes();
        test_random_keys();

        wait_block_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("string_key_bucket_hash_top: match");
        else
            $display("string_key_bucket_hash_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/skbh_pkg.sv
rtl/skbh_crc.sv
rtl/skbh_mix.sv
rtl/skbh_scale.sv
rtl/string_key_bucket_hash_top.sv
tb/string_key_bucket_hash_top_test.sv
